>>> src/sfa_pkg.sv
package sfa_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic REG_FIT_MODE = 1'b0;
  localparam logic REG_POOL_LEN = 1'b1;

  typedef struct packed {
    logic fits;
    logic shorter;
    logic overlap;
    logic below;
  } cmp_t;

endpackage

>>> src/sfa_cmp_unit.sv
module sfa_cmp_unit #(
  parameter int ADDR_WIDTH = 15
) (
  input  logic [ADDR_WIDTH-1:0] ent_start,
  input  logic [ADDR_WIDTH-1:0] ent_len,
  input  logic [ADDR_WIDTH-1:0] req_len,
  input  logic [ADDR_WIDTH-1:0] req_base,
  input  logic [ADDR_WIDTH:0]   req_end,
  input  logic [ADDR_WIDTH-1:0] pick_len,
  output logic [ADDR_WIDTH:0]   ent_end,
  output sfa_pkg::cmp_t         flags
);
  import sfa_pkg::*;

  assign ent_end       = {1'b0, ent_start} + {1'b0, ent_len};
  assign flags.fits    = ent_len >= req_len;
  assign flags.shorter = ent_len < pick_len;
  assign flags.overlap = ({1'b0, req_base} < ent_end) && ({1'b0, ent_start} < req_end);
  assign flags.below   = ent_start < req_base;

endmodule

>>> src/segment_allocator_first_best_fit_core.sv
// A transaction is accepted in S_IDLE, then scans one free-table entry a cycle (at most count,
// fewer when first fit stops early), then passes through the update and result-load states.
// Transactions are handled one at a time on the single shared compare unit. Zero-length
// requests and out-of-pool releases skip the scan and update; a held result stalls the
// result load, and a new transaction is accepted only after the result is loaded.
// Reset (rst_n low, synchronous) gives first fit, one free segment of 32767 units, no result.
module segment_allocator_first_best_fit_core #(
  parameter int MAX_SEGMENTS = 16,
  parameter int ADDR_WIDTH   = 15
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // cmd, base_address, length
  input  logic [((2*ADDR_WIDTH+1+7)/8)*8-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // status, granted_address
  output logic [((ADDR_WIDTH+2+7)/8)*8-1:0]      out_tdata,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [2:0]                             cfg_paddr,
  input  logic [31:0]                            cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);
  import sfa_pkg::*;

  localparam int AW  = ADDR_WIDTH;
  localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int OTW = ((AW + 2 + 7) / 8) * 8;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_RESP} state_t;

  state_t           state_r;
  logic             fit_mode_r;
  logic [AW-1:0]    pool_r;
  logic [AW-1:0]    seg_start_r [MAX_SEGMENTS];
  logic [AW-1:0]    seg_len_r   [MAX_SEGMENTS];
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    idx_r;
  logic             cmd_r;
  logic [AW-1:0]    base_r;
  logic [AW-1:0]    len_r;
  logic [AW:0]      end_r;
  logic             found_r;
  logic [CW-1:0]    pick_r;
  logic [AW-1:0]    pick_start_r;
  logic [AW-1:0]    pick_len_r;
  logic             bad_r;
  logic [AW:0]      prev_end_r;
  logic [AW-1:0]    prev_len_r;
  logic [AW-1:0]    next_start_r;
  logic [AW-1:0]    next_len_r;
  logic             out_valid_r;
  status_t          out_status_r;
  logic [AW-1:0]    out_grant_r;
  status_t          res_status_r;
  logic [AW-1:0]    res_grant_r;

  logic [AW-1:0]    ent_start;
  logic [AW-1:0]    ent_len;
  logic [AW:0]      ent_end;
  cmp_t             flags;
  logic             last_ent;
  logic             cfg_wr;
  logic [AW:0]      in_end;
  logic             has_prev;
  logic             has_next;

  assign ent_start = seg_start_r[idx_r[IW-1:0]];
  assign ent_len   = seg_len_r[idx_r[IW-1:0]];
  assign last_ent  = (idx_r + 1'b1) >= count_r;
  assign in_end    = {1'b0, in_tdata[AW:1]} + {1'b0, in_tdata[2*AW:AW+1]};
  assign has_prev  = (pick_r != '0) && (prev_end_r == {1'b0, base_r});
  assign has_next  = (pick_r < count_r) && ({1'b0, next_start_r} == end_r);

  sfa_cmp_unit #(.ADDR_WIDTH(AW)) u_cmp (
    .ent_start (ent_start),
    .ent_len   (ent_len),
    .req_len   (len_r),
    .req_base  (base_r),
    .req_end   (end_r),
    .pick_len  (pick_len_r),
    .ent_end   (ent_end),
    .flags     (flags)
  );

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_POOL_LEN) ? 32'(pool_r) : 32'(fit_mode_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OTW'({out_grant_r, out_status_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fit_mode_r   <= 1'b0;
      pool_r       <= AW'(32767);
      count_r      <= CW'(1);
      seg_start_r[0] <= '0;
      seg_len_r[0] <= AW'(32767);
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_FIT_MODE) begin
          fit_mode_r <= cfg_pwdata[0];
        end else begin
          pool_r         <= cfg_pwdata[AW-1:0];
          seg_start_r[0] <= '0;
          seg_len_r[0]   <= cfg_pwdata[AW-1:0];
          count_r        <= (cfg_pwdata[AW-1:0] != '0) ? CW'(1) : '0;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r      <= in_tdata[0];
            base_r     <= in_tdata[AW:1];
            len_r      <= in_tdata[2*AW:AW+1];
            end_r      <= in_end;
            idx_r      <= '0;
            found_r    <= 1'b0;
            bad_r      <= 1'b0;
            pick_r     <= count_r;
            pick_len_r <= '0;
            prev_end_r <= '0;
            prev_len_r <= '0;
            if (in_tdata[2*AW:AW+1] == '0) begin
              res_status_r <= (in_tdata[0] == CMD_ALLOC) ? ST_NOFIT : ST_INVALID;
              res_grant_r  <= '0;
              state_r      <= S_RESP;
            end else if (in_tdata[0] == CMD_RELEASE && in_end > {1'b0, pool_r}) begin
              res_status_r <= ST_INVALID;
              res_grant_r  <= '0;
              state_r      <= S_RESP;
            end else if (count_r == '0) begin
              state_r <= S_APPLY;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + 1'b1;
          if (cmd_r == CMD_ALLOC) begin
            if (flags.fits && (!found_r || flags.shorter)) begin
              found_r      <= 1'b1;
              pick_r       <= idx_r;
              pick_start_r <= ent_start;
              pick_len_r   <= ent_len;
            end
            if (last_ent || (flags.fits && !found_r && !fit_mode_r)) begin
              state_r <= S_APPLY;
            end
          end else begin
            if (flags.overlap) begin
              bad_r <= 1'b1;
            end
            if (flags.below) begin
              prev_end_r <= ent_end;
              prev_len_r <= ent_len;
            end else if (!found_r) begin
              found_r      <= 1'b1;
              pick_r       <= idx_r;
              next_start_r <= ent_start;
              next_len_r   <= ent_len;
            end
            if (last_ent) begin
              state_r <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          state_r      <= S_RESP;
          res_status_r <= ST_OK;
          res_grant_r  <= '0;
          if (cmd_r == CMD_ALLOC) begin
            if (!found_r) begin
              res_status_r <= ST_NOFIT;
            end else begin
              res_grant_r <= pick_start_r;
              if (pick_len_r == len_r) begin
                for (int j = 0; j < MAX_SEGMENTS - 1; j++) begin
                  if (CW'(j) >= pick_r && CW'(j + 1) < count_r) begin
                    seg_start_r[j] <= seg_start_r[j+1];
                    seg_len_r[j]   <= seg_len_r[j+1];
                  end
                end
                count_r <= count_r - 1'b1;
              end else begin
                seg_start_r[pick_r[IW-1:0]] <= pick_start_r + len_r;
                seg_len_r[pick_r[IW-1:0]]   <= pick_len_r - len_r;
              end
            end
          end else if (bad_r) begin
            res_status_r <= ST_INVALID;
          end else if (has_prev && has_next) begin
            seg_len_r[IW'(pick_r - 1'b1)] <= prev_len_r + len_r + next_len_r;
            for (int j = 0; j < MAX_SEGMENTS - 1; j++) begin
              if (CW'(j) >= pick_r && CW'(j + 1) < count_r) begin
                seg_start_r[j] <= seg_start_r[j+1];
                seg_len_r[j]   <= seg_len_r[j+1];
              end
            end
            count_r <= count_r - 1'b1;
          end else if (has_prev) begin
            seg_len_r[IW'(pick_r - 1'b1)] <= prev_len_r + len_r;
          end else if (has_next) begin
            seg_start_r[pick_r[IW-1:0]] <= base_r;
            seg_len_r[pick_r[IW-1:0]]   <= next_len_r + len_r;
          end else if (count_r >= CW'(MAX_SEGMENTS)) begin
            res_status_r <= ST_FULL;
          end else begin
            for (int j = 1; j < MAX_SEGMENTS; j++) begin
              if (CW'(j) > pick_r && CW'(j) <= count_r) begin
                seg_start_r[j] <= seg_start_r[j-1];
                seg_len_r[j]   <= seg_len_r[j-1];
              end
            end
            seg_start_r[pick_r[IW-1:0]] <= base_r;
            seg_len_r[pick_r[IW-1:0]]   <= len_r;
            count_r <= count_r + 1'b1;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_grant_r  <= res_grant_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SEGMENTS))
    else $error("free table count exceeds capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r < count_r)
    else $error("scan index beyond table fill");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_grant_r == '0)
    else $error("granted address set on failed transaction");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPLY && !cfg_wr |=>
      count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
      count_r == $past(count_r) - 1'b1)
    else $error("table count changed by more than one entry");
`endif

endmodule

>>> dv/segment_allocator_first_best_fit_core_checker.sv
module segment_allocator_first_best_fit_core_checker
  import sfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fails,
  output int          outstanding
);

  typedef struct packed {
    status_t     st;
    logic [14:0] addr;
  } answer_t;

  localparam int NSEG = 16;

  logic        best_fit;
  int          pool_size;
  int          seg_base [NSEG];
  int          seg_len  [NSEG];
  int          seg_cnt;
  answer_t     answer_q [$];

  function automatic void clear_table();
    for (int i = 0; i < NSEG; i++) begin
      seg_base[i] = 0;
      seg_len[i]  = 0;
    end
    seg_cnt = (pool_size != 0) ? 1 : 0;
    seg_len[0] = pool_size;
  endfunction

  function automatic void drop_seg(int idx);
    for (int i = idx; i + 1 < seg_cnt; i++) begin
      seg_base[i] = seg_base[i+1];
      seg_len[i]  = seg_len[i+1];
    end
    seg_cnt--;
    seg_base[seg_cnt] = 0;
    seg_len[seg_cnt]  = 0;
  endfunction

  function automatic answer_t grant(int req);
    answer_t a;
    int pick;
    a.st = ST_NOFIT;
    a.addr = '0;
    pick = -1;
    if (req == 0) return a;
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_len[i] >= req) begin
        if (pick < 0) begin
          pick = i;
          if (!best_fit) break;
        end else if (seg_len[i] < seg_len[pick]) begin
          pick = i;
        end
      end
    end
    if (pick < 0) return a;
    a.st = ST_OK;
    a.addr = seg_base[pick][14:0];
    if (seg_len[pick] == req) drop_seg(pick);
    else begin
      seg_base[pick] = (seg_base[pick] + req) & 32'h7fff;
      seg_len[pick]  = seg_len[pick] - req;
    end
    return a;
  endfunction

  function automatic status_t give_back(int b, int len);
    int pos;
    int e;
    logic prv;
    logic nxt;
    e = b + len;
    if (len == 0 || e > pool_size) return ST_INVALID;
    for (int i = 0; i < seg_cnt; i++)
      if (b < seg_base[i] + seg_len[i] && seg_base[i] < e) return ST_INVALID;
    pos = 0;
    while (pos < seg_cnt && seg_base[pos] < b) pos++;
    prv = pos > 0 && seg_base[pos-1] + seg_len[pos-1] == b;
    nxt = pos < seg_cnt && seg_base[pos] == e;
    if (prv && nxt) begin
      seg_len[pos-1] = (seg_len[pos-1] + len + seg_len[pos]) & 32'h7fff;
      drop_seg(pos);
    end else if (prv) begin
      seg_len[pos-1] = (seg_len[pos-1] + len) & 32'h7fff;
    end else if (nxt) begin
      seg_base[pos] = b;
      seg_len[pos]  = (seg_len[pos] + len) & 32'h7fff;
    end else begin
      if (seg_cnt >= NSEG) return ST_FULL;
      for (int i = seg_cnt; i > pos; i--) begin
        seg_base[i] = seg_base[i-1];
        seg_len[i]  = seg_len[i-1];
      end
      seg_base[pos] = b;
      seg_len[pos]  = len;
      seg_cnt++;
    end
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    answer_t a;
    answer_t got;
    if (!rst_n) begin
      best_fit  = 1'b0;
      pool_size = 32767;
      clear_table();
      answer_q.delete();
      fails = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_FIT_MODE) best_fit = cfg_pwdata[0];
        else begin
          pool_size = cfg_pwdata[14:0];
          clear_table();
        end
      end
      if (in_tvalid && in_tready) begin
        a.addr = '0;
        if (in_tdata[0] == CMD_ALLOC) a = grant(in_tdata[30:16]);
        else a.st = give_back(in_tdata[15:1], in_tdata[30:16]);
        answer_q.push_back(a);
      end
      if (out_tvalid && out_tready) begin
        got.st   = status_t'(out_tdata[1:0]);
        got.addr = out_tdata[16:2];
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result status %0d address %0d", $time, got.st, got.addr);
          fails++;
        end else begin
          a = answer_q.pop_front();
          if (got.st !== a.st) begin
            $display("%0t: status expected %0d actual %0d", $time, a.st, got.st);
            fails++;
          end
          if (got.addr !== a.addr) begin
            $display("%0t: address expected %0d actual %0d", $time, a.addr, got.addr);
            fails++;
          end
        end
      end
    end
    outstanding = answer_q.size();
  end

endmodule

>>> dv/segment_allocator_first_best_fit_core_tb.sv
module segment_allocator_first_best_fit_core_tb;
  import sfa_pkg::*;

  localparam int LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fails;
  int          outstanding;
  int          cycles = 0;
  int          tx_idle = 0;
  int          rx_idle = 0;
  int          pool_now = 32767;
  logic [30:0] sent_q [$];
  logic [29:0] held_q [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  segment_allocator_first_best_fit_core u_dut (.*);

  segment_allocator_first_best_fit_core_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("segment_allocator_first_best_fit_core_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic [30:0] s;
    out_tready <= $urandom_range(99) >= rx_idle;
    if (rst_n && out_tvalid && out_tready && sent_q.size() > 0) begin
      s = sent_q.pop_front();
      if (s[0] == CMD_ALLOC && out_tdata[1:0] == ST_OK)
        held_q.push_back({out_tdata[16:2], s[30:16]});
    end
  end

  task automatic send(logic c, int b, int len);
    logic acc;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, len[14:0], b[14:0], c};
    do begin
      @(negedge clk);
      acc = in_tready;
      @(posedge clk);
    end while (!acc);
    sent_q.push_back({len[14:0], b[14:0], c});
    if ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic set_reg(logic idx, int v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_POOL_LEN) begin
      pool_now = v;
      held_q.delete();
    end
  endtask

  task automatic random_item();
    int r;
    int k;
    logic [29:0] h;
    r = $urandom_range(99);
    if (r < 55) begin
      send(CMD_ALLOC, $urandom, $urandom_range(0, pool_now / 6 + 1));
    end else if (r < 88 && held_q.size() > 0) begin
      k = $urandom_range(held_q.size() - 1);
      h = held_q[k];
      held_q.delete(k);
      send(CMD_RELEASE, h[29:15], h[14:0]);
    end else if (r < 94) begin
      send(CMD_RELEASE, $urandom_range(0, pool_now), $urandom_range(0, pool_now / 4 + 1));
    end else begin
      send(1'($urandom_range(1)), $urandom_range(0, 32767), $urandom_range(0, 32767));
    end
  endtask

  initial begin
    int pools [4];
    pools = '{32767, 1, 60, 400};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(CMD_ALLOC, 0, 0);
    send(CMD_ALLOC, 32767, 100);
    send(CMD_ALLOC, 0, 32767);
    send(CMD_RELEASE, 0, 0);
    send(CMD_RELEASE, 32767, 1);
    send(CMD_RELEASE, 100, 5);
    send(CMD_RELEASE, 0, 100);
    send(CMD_ALLOC, 0, 32767);
    send(CMD_RELEASE, 0, 32767);
    set_reg(REG_POOL_LEN, 33);
    send(CMD_ALLOC, 0, 33);
    for (int i = 0; i < 16; i++) send(CMD_RELEASE, 2 * i, 1);
    send(CMD_RELEASE, 32, 1);
    send(CMD_RELEASE, 1, 1);
    set_reg(REG_POOL_LEN, 0);
    send(CMD_ALLOC, 0, 1);
    send(CMD_RELEASE, 0, 1);

    for (int p = 0; p < 3; p++) begin
      tx_idle = (p == 0) ? 26 : (p == 1) ? 74 : 0;
      rx_idle = (p == 0) ? 74 : (p == 1) ? 26 : 0;
      for (int k = 0; k < 4; k++) begin
        set_reg(REG_FIT_MODE, (k + p) & 1);
        set_reg(REG_POOL_LEN, pools[k]);
        repeat (92) random_item();
      end
    end

    in_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0) $display("segment_allocator_first_best_fit_core_tb: clean");
    else $display("segment_allocator_first_best_fit_core_tb: errors");
    $finish;
  end

endmodule

>>> files.f
src/sfa_pkg.sv
src/sfa_cmp_unit.sv
src/segment_allocator_first_best_fit_core.sv
dv/segment_allocator_first_best_fit_core_checker.sv
dv/segment_allocator_first_best_fit_core_tb.sv
